@@ sv/epr_pkg.sv @@
`default_nettype none

package epr_pkg;

    // opcodes of an input transaction
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_TIMER = 2'd1;
    localparam logic [1:0] OP_POLL  = 2'd2;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_CM = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POLL_LIMIT   = 1'd1;

    // field widths
    localparam int unsigned OPCODE_W  = 2;
    localparam int unsigned CAPTURE_W = 32;
    localparam int unsigned TPC_W     = 16;
    localparam int unsigned POLL_W    = 8;
    localparam int unsigned DIST_W    = 16;
    localparam int unsigned PHASE_W   = 2;

    localparam logic [TPC_W-1:0]  TPC_RESET        = 16'd58;
    localparam logic [POLL_W-1:0] POLL_LIMIT_RESET = 8'hFF;

    localparam logic [PHASE_W-1:0] PHASE_WAIT = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_HIGH = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_DONE = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_div;
    } t_dp_stat;

endpackage

`default_nettype wire

@@ sv/epr_in_if.sv @@
`default_nettype none

interface epr_in_if
    import epr_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [OPCODE_W-1:0]  opcode;
    logic                 overflow_seen;
    logic                 edge_seen;
    logic [CAPTURE_W-1:0] capture_value;

    modport source (
        output valid, opcode, overflow_seen, edge_seen, capture_value,
        input  ready
    );

    modport sink (
        input  valid, opcode, overflow_seen, edge_seen, capture_value,
        output ready
    );
endinterface

`default_nettype wire

@@ sv/epr_out_if.sv @@
`default_nettype none

interface epr_out_if
    import epr_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               result_ready;
    logic               timed_out;
    logic [DIST_W-1:0]  distance_cm;
    logic [PHASE_W-1:0] phase;

    modport source (
        output valid, result_ready, timed_out, distance_cm, phase,
        input  ready
    );

    modport sink (
        input  valid, result_ready, timed_out, distance_cm, phase,
        output ready
    );
endinterface

`default_nettype wire

@@ sv/echo_pulse_ranger.sv @@
// channel  | dir | handshake       | payload
// i_in     | in  | valid / ready   | opcode, overflow_seen, edge_seen, capture_value
// o_out    | out | valid / ready   | result_ready, timed_out, distance_cm, phase
// i_cfg_*  | in  | write enable    | index (0 ticks_per_cm, 1 poll_limit), 16-bit data
//
// start, timer event and unfinished poll: accepted in S_IDLE, then the output register
//   is loaded from S_PUSH once the output is free
// completed poll: accepted in S_IDLE, divided in S_DIV, then loaded from S_PUSH; the
//   restoring divider retires one quotient bit a cycle over the whole dividend
// one transaction is in flight at a time; the next is taken once its result is loaded
// reset is synchronous, active low: no clearing pass, state and settings back to defaults
// a stalled output holds its result while the next transaction is already accepted
`default_nettype none

module echo_pulse_ranger
    import epr_pkg::*;
#(
    parameter int unsigned OVERFLOW_BITS = 6,
    parameter int unsigned COUNTER_BITS  = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    epr_in_if.sink                     i_in,
    epr_out_if.source                  o_out
);
    // dividend width: overflow count times counter range plus captured ticks
    localparam int unsigned TOTAL_BITS = OVERFLOW_BITS + COUNTER_BITS;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // sequencer: accept, iterate the divider, load the output register
    epr_ctrl #(
        .TOTAL_BITS (TOTAL_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // measurement state, configuration, divider and result register
    epr_datapath #(
        .OVERFLOW_BITS (OVERFLOW_BITS),
        .COUNTER_BITS  (COUNTER_BITS),
        .TOTAL_BITS    (TOTAL_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_opcode        (i_in.opcode),
        .i_overflow_seen (i_in.overflow_seen),
        .i_edge_seen     (i_in.edge_seen),
        .i_capture_value (i_in.capture_value),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_result_ready  (o_out.result_ready),
        .o_timed_out     (o_out.timed_out),
        .o_distance_cm   (o_out.distance_cm),
        .o_phase         (o_out.phase)
    );

endmodule

`default_nettype wire

@@ sv/epr_ctrl.sv @@
`default_nettype none

module epr_ctrl
    import epr_pkg::*;
#(
    parameter int unsigned TOTAL_BITS = 38
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire logic     i_out_ready,
    output logic          o_out_valid,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);
    localparam int unsigned CW = $clog2(TOTAL_BITS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_PUSH
    } t_state;

    t_state        r_state;
    logic [CW-1:0] r_steps;
    logic          r_out_valid;

    always_comb begin
        o_cmd.accept   = i_in_valid && (r_state == S_IDLE);
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.out_load = (r_state == S_PUSH) && (!r_out_valid || i_out_ready);
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_steps     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd.accept) begin
                        if (i_stat.need_div) begin
                            r_state <= S_DIV;
                            r_steps <= CW'(TOTAL_BITS - 1);
                        end else begin
                            r_state <= S_PUSH;
                        end
                    end
                end
                S_DIV: begin
                    if (r_steps == '0) begin
                        r_state <= S_PUSH;
                    end else begin
                        r_steps <= r_steps - 1'b1;
                    end
                end
                S_PUSH: begin
                    if (o_cmd.out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_div_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept && i_stat.need_div |=> r_state == S_DIV && r_steps == CW'(TOTAL_BITS - 1))
        else $error("division not started after completed poll");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> r_out_valid && r_state == S_IDLE)
        else $error("result load did not raise output valid");

endmodule

`default_nettype wire

@@ sv/epr_datapath.sv @@
`default_nettype none

module epr_datapath
    import epr_pkg::*;
#(
    parameter int unsigned OVERFLOW_BITS = 6,
    parameter int unsigned COUNTER_BITS  = 32,
    parameter int unsigned TOTAL_BITS    = OVERFLOW_BITS + COUNTER_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [OPCODE_W-1:0]   i_opcode,
    input  wire logic                  i_overflow_seen,
    input  wire logic                  i_edge_seen,
    input  wire logic [CAPTURE_W-1:0]  i_capture_value,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_stat                   o_stat,
    output logic                       o_result_ready,
    output logic                       o_timed_out,
    output logic [DIST_W-1:0]          o_distance_cm,
    output logic [PHASE_W-1:0]         o_phase
);
    localparam int unsigned QW = (TOTAL_BITS > DIST_W + 1) ? TOTAL_BITS : DIST_W + 1;

    // configuration
    logic [TPC_W-1:0]  r_ticks_per_cm;
    logic [POLL_W-1:0] r_poll_limit;

    // measurement state
    logic                     r_armed;
    logic                     r_pulse_high;
    logic                     r_capture_done;
    logic [OVERFLOW_BITS-1:0] r_ovf_count;
    logic [COUNTER_BITS-1:0]  r_pulse_ticks;
    logic [POLL_W-1:0]        r_poll_count;

    logic                     n_armed;
    logic                     n_pulse_high;
    logic                     n_capture_done;
    logic [OVERFLOW_BITS-1:0] n_ovf_count;
    logic [COUNTER_BITS-1:0]  n_pulse_ticks;
    logic [POLL_W-1:0]        n_poll_count;
    logic                     n_res_ready;
    logic                     n_res_tout;

    // staged result and divider
    logic                  r_res_ready;
    logic                  r_res_tout;
    logic [TOTAL_BITS-1:0] r_dq;
    logic [TPC_W-1:0]      r_rem;
    logic [TPC_W-1:0]      r_div;

    logic [TOTAL_BITS-1:0] total;
    logic [TPC_W:0]        rem_sh;
    logic                  ge;
    logic [QW-1:0]         q_ext;
    logic [DIST_W-1:0]     dist_sat;
    logic [PHASE_W-1:0]    phase_now;

    assign o_stat.need_div = (i_opcode == OP_POLL) && r_capture_done;

    // overflow_count * (2^COUNTER_BITS - 1) + pulse_ticks
    assign total = TOTAL_BITS'({r_ovf_count, {COUNTER_BITS{1'b0}}})
                 - TOTAL_BITS'(r_ovf_count) + TOTAL_BITS'(r_pulse_ticks);

    assign rem_sh = {r_rem, r_dq[TOTAL_BITS-1]};
    assign ge     = (rem_sh >= {1'b0, r_div});

    assign q_ext    = QW'(r_dq);
    assign dist_sat = (|q_ext[QW-1:DIST_W]) ? {DIST_W{1'b1}} : q_ext[DIST_W-1:0];

    always_comb begin
        if (r_capture_done) begin
            phase_now = PHASE_DONE;
        end else if (r_pulse_high) begin
            phase_now = PHASE_HIGH;
        end else begin
            phase_now = PHASE_WAIT;
        end
    end

    always_comb begin
        n_armed        = r_armed;
        n_pulse_high   = r_pulse_high;
        n_capture_done = r_capture_done;
        n_ovf_count    = r_ovf_count;
        n_pulse_ticks  = r_pulse_ticks;
        n_poll_count   = r_poll_count;
        n_res_ready    = 1'b0;
        n_res_tout     = 1'b0;
        unique case (i_opcode)
            OP_START: begin
                n_armed      = 1'b1;
                n_poll_count = '0;
            end
            OP_TIMER: begin
                if (r_armed && !r_capture_done) begin
                    // overflow is handled before the edge
                    if (i_overflow_seen && r_pulse_high) begin
                        if (&r_ovf_count) begin
                            n_capture_done = 1'b1;
                            n_pulse_ticks  = {COUNTER_BITS{1'b1}};
                        end else begin
                            n_ovf_count = r_ovf_count + 1'b1;
                        end
                    end
                    if (i_edge_seen) begin
                        if (r_pulse_high) begin
                            n_capture_done = 1'b1;
                            n_pulse_ticks  = i_capture_value[COUNTER_BITS-1:0];
                        end else begin
                            n_ovf_count   = '0;
                            n_pulse_ticks = '0;
                            n_pulse_high  = 1'b1;
                        end
                    end
                end
            end
            OP_POLL: begin
                if (r_capture_done) begin
                    n_res_ready    = 1'b1;
                    n_capture_done = 1'b0;
                    n_pulse_high   = 1'b0;
                    n_ovf_count    = '0;
                    n_armed        = 1'b0;
                end else if (r_poll_count >= r_poll_limit) begin
                    n_res_tout = 1'b1;
                    n_armed    = 1'b0;
                end else begin
                    n_poll_count = r_poll_count + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks_per_cm <= TPC_RESET;
            r_poll_limit   <= POLL_LIMIT_RESET;
            r_armed        <= 1'b0;
            r_pulse_high   <= 1'b0;
            r_capture_done <= 1'b0;
            r_ovf_count    <= '0;
            r_pulse_ticks  <= '0;
            r_poll_count   <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_TICKS_PER_CM: r_ticks_per_cm <= i_cfg_data[TPC_W-1:0];
                    CFG_POLL_LIMIT:   r_poll_limit   <= i_cfg_data[POLL_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.accept) begin
                r_armed        <= n_armed;
                r_pulse_high   <= n_pulse_high;
                r_capture_done <= n_capture_done;
                r_ovf_count    <= n_ovf_count;
                r_pulse_ticks  <= n_pulse_ticks;
                r_poll_count   <= n_poll_count;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_res_ready <= n_res_ready;
            r_res_tout  <= n_res_tout;
            if (o_stat.need_div) begin
                r_dq  <= total;
                r_rem <= '0;
                r_div <= (r_ticks_per_cm == '0) ? TPC_W'(1) : r_ticks_per_cm;
            end
        end else if (i_cmd.div_step) begin
            r_rem <= ge ? TPC_W'(rem_sh - {1'b0, r_div}) : rem_sh[TPC_W-1:0];
            r_dq  <= {r_dq[TOTAL_BITS-2:0], ge};
        end
        if (i_cmd.out_load) begin
            o_result_ready <= r_res_ready;
            o_timed_out    <= r_res_tout;
            o_distance_cm  <= r_res_ready ? dist_sat : '0;
            o_phase        <= phase_now;
        end
    end

    a_done_needs_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_capture_done |-> r_pulse_high)
        else $error("measurement done without a pulse");

    a_poll_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.accept && o_stat.need_div
            |=> !r_capture_done && !r_armed && r_ovf_count == '0 && r_res_ready)
        else $error("completed poll did not clear the measurement");

endmodule

`default_nettype wire

@@ verif/echo_pulse_ranger_tb.sv @@
`timescale 1ns / 100ps

module echo_pulse_ranger_tb;
    import epr_pkg::*;

    // opcode 3 has no meaning and must leave the state alone
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    localparam logic [5:0]           OVF_FULL  = 6'h3F;
    localparam logic [CAPTURE_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;

    // a completed poll runs the whole divider, so leave some margin when settling
    localparam int unsigned DRAIN_CYCLES = 50;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned PHASE_ITEMS  = 30;
    localparam int unsigned STORM_POLLS  = 258;

    typedef struct packed {
        logic               result_ready;
        logic               timed_out;
        logic [DIST_W-1:0]  distance_cm;
        logic [PHASE_W-1:0] phase;
    } t_echo_reading;

    // predicts the reading for every accepted transaction and checks the block against it
    class echo_ranger_scoreboard;
        logic [TPC_W-1:0]     ticks_per_cm;
        logic [POLL_W-1:0]    poll_limit;
        bit                   armed;
        bit                   pulse_high;
        bit                   capture_done;
        bit [5:0]             overflows;
        bit [CAPTURE_W-1:0]   pulse_ticks;
        bit [POLL_W-1:0]      polls;
        t_echo_reading        expected_readings[$];
        int unsigned          errors;

        function new();
            ticks_per_cm = TPC_RESET;
            poll_limit   = POLL_LIMIT_RESET;
            armed        = 1'b0;
            pulse_high   = 1'b0;
            capture_done = 1'b0;
            overflows    = '0;
            pulse_ticks  = '0;
            polls        = '0;
            errors       = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] index,
                                     logic [CFG_DATA_W-1:0] data);
            if (index == CFG_TICKS_PER_CM) begin
                ticks_per_cm = data[TPC_W-1:0];
            end else if (index == CFG_POLL_LIMIT) begin
                poll_limit = data[POLL_W-1:0];
            end
        endfunction

        function logic [DIST_W-1:0] distance();
            logic [63:0] total;
            logic [63:0] divisor;
            logic [63:0] quotient;
            // a zero divisor behaves as one
            divisor  = (ticks_per_cm == '0) ? 64'd1 : 64'(ticks_per_cm);
            total    = 64'(overflows) * 64'(COUNT_MAX) + 64'(pulse_ticks);
            quotient = total / divisor;
            return (quotient > 64'd65535) ? '1 : quotient[DIST_W-1:0];
        endfunction

        function void timer_event(bit ovf_hit, bit edge_hit, logic [CAPTURE_W-1:0] cap);
            // timer stopped, or a finished measurement not yet read
            if (!armed || capture_done) begin
                return;
            end
            // overflow is handled before the edge
            if (ovf_hit && pulse_high) begin
                if (overflows == OVF_FULL) begin
                    capture_done = 1'b1;
                    pulse_ticks  = COUNT_MAX;
                end else begin
                    overflows = overflows + 6'd1;
                end
            end
            if (edge_hit) begin
                if (pulse_high) begin
                    capture_done = 1'b1;
                    pulse_ticks  = cap;
                end else begin
                    overflows   = '0;
                    pulse_ticks = '0;
                    pulse_high  = 1'b1;
                end
            end
        endfunction

        function void accept_command(logic [OPCODE_W-1:0] opcode, logic ovf_hit,
                                     logic edge_hit, logic [CAPTURE_W-1:0] cap);
            t_echo_reading reading;
            reading = '0;
            case (opcode)
                OP_START: begin
                    armed = 1'b1;
                    polls = '0;
                end
                OP_TIMER: begin
                    timer_event(ovf_hit, edge_hit, cap);
                end
                OP_POLL: begin
                    if (capture_done) begin
                        reading.result_ready = 1'b1;
                        reading.distance_cm  = distance();
                        capture_done         = 1'b0;
                        pulse_high           = 1'b0;
                        overflows            = '0;
                        armed                = 1'b0;
                    end else if (polls >= poll_limit) begin
                        reading.timed_out = 1'b1;
                        armed             = 1'b0;
                    end else begin
                        polls = polls + 8'd1;
                    end
                end
                default: begin
                end
            endcase
            reading.phase = capture_done ? PHASE_DONE : (pulse_high ? PHASE_HIGH : PHASE_WAIT);
            expected_readings.push_back(reading);
        endfunction

        function void check_reading(logic result_ready, logic timed_out,
                                    logic [DIST_W-1:0] distance_cm, logic [PHASE_W-1:0] phase);
            t_echo_reading want;
            if (expected_readings.size() == 0) begin
                $error("result with no transaction outstanding: ready %0b timed_out %0b dist %0d",
                       result_ready, timed_out, distance_cm);
                errors++;
                return;
            end
            want = expected_readings.pop_front();
            if (result_ready !== want.result_ready) begin
                $error("result_ready: expected %0b, actual %0b", want.result_ready, result_ready);
                errors++;
            end
            if (timed_out !== want.timed_out) begin
                $error("timed_out: expected %0b, actual %0b", want.timed_out, timed_out);
                errors++;
            end
            if (distance_cm !== want.distance_cm) begin
                $error("distance_cm: expected %0d, actual %0d", want.distance_cm, distance_cm);
                errors++;
            end
            if (phase !== want.phase) begin
                $error("phase: expected %0d, actual %0d", want.phase, phase);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return expected_readings.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    epr_in_if  in_if ();
    epr_out_if out_if ();

    echo_ranger_scoreboard board = new();

    // idling odds in percent per cycle, and the long receiver hold-off
    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    logic        rx_hold;
    int unsigned items_sent;

    echo_pulse_ranger dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    always #5 i_clk = ~i_clk;

    // receiver: random back-pressure, or a solid stall while the hold-off runs
    always @(posedge i_clk) begin
        if (rx_hold) begin
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // every result transaction is checked against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            board.check_reading(out_if.result_ready, out_if.timed_out,
                                out_if.distance_cm, out_if.phase);
        end
    end

    // offer one input transaction, possibly after some idle cycles, and wait for it to go in
    task automatic send(input logic [OPCODE_W-1:0] op, input logic ovf_hit,
                        input logic edge_hit, input logic [CAPTURE_W-1:0] cap);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid         <= 1'b1;
        in_if.opcode        <= op;
        in_if.overflow_seen <= ovf_hit;
        in_if.edge_seen     <= edge_hit;
        in_if.capture_value <= cap;
        do @(posedge i_clk); while (!in_if.ready);
        board.accept_command(op, ovf_hit, edge_hit, cap);
        items_sent++;
    endtask

    function automatic logic rand_bit();
        return 1'($urandom_range(1));
    endfunction

    function automatic logic [CAPTURE_W-1:0] rand_capture();
        case ($urandom_range(3))
            0: return $urandom;
            // short pulses of at most 4_000_000 ticks
            1: return $urandom_range(4_000_000);
            2: return $urandom_range(1) ? COUNT_MAX : '0;
            default: return $urandom >> $urandom_range(31);
        endcase
    endfunction

    // stop offering, let every result come back, then give the divider time to go quiet
    task automatic settle();
        in_if.valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // both registers back to back, only ever called while the block is idle
    task automatic write_settings(input logic [TPC_W-1:0] tpc, input logic [POLL_W-1:0] limit);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_TICKS_PER_CM;
        i_cfg_data  <= CFG_DATA_W'(tpc);
        @(posedge i_clk);
        board.write_register(CFG_TICKS_PER_CM, CFG_DATA_W'(tpc));
        i_cfg_index <= CFG_POLL_LIMIT;
        i_cfg_data  <= CFG_DATA_W'(limit);
        @(posedge i_clk);
        board.write_register(CFG_POLL_LIMIT, CFG_DATA_W'(limit));
        i_cfg_we <= 1'b0;
    endtask

    // start, rising edge, some overflows, falling edge, then polls
    // now and then a poll lands mid-pulse, which may time out and break the sequence
    task automatic run_measurement();
        int unsigned n_ovf;
        send(OP_START, rand_bit(), rand_bit(), rand_capture());
        if ($urandom_range(9) == 0) begin
            send(OP_POLL, rand_bit(), rand_bit(), rand_capture());
        end
        send(OP_TIMER, rand_bit(), 1'b1, rand_capture());
        // one in five pulses gets 60 to 66 overflows, near or past the top of the overflow count
        n_ovf = ($urandom_range(99) < 20) ? $urandom_range(60, 66) : $urandom_range(3);
        repeat (n_ovf) begin
            if ($urandom_range(99) < 5) begin
                send(OP_POLL, rand_bit(), rand_bit(), rand_capture());
            end
            send(OP_TIMER, 1'b1, 1'b0, rand_capture());
        end
        send(OP_TIMER, rand_bit(), 1'b1, rand_capture());
        // late timer events after done must be ignored
        if ($urandom_range(3) == 0) begin
            send(OP_TIMER, rand_bit(), rand_bit(), rand_capture());
        end
        repeat ($urandom_range(1, 3)) begin
            send(OP_POLL, rand_bit(), rand_bit(), rand_capture());
        end
    endtask

    // armed but never finishing, so polls count towards the limit
    task automatic run_timeout();
        send(OP_START, rand_bit(), rand_bit(), rand_capture());
        if ($urandom_range(1)) begin
            send(OP_TIMER, 1'b0, 1'b1, rand_capture());
        end
        repeat ($urandom_range(1, 6)) begin
            send(OP_POLL, rand_bit(), rand_bit(), rand_capture());
        end
    endtask

    task automatic run_phase(input logic [TPC_W-1:0] tpc, input logic [POLL_W-1:0] limit,
                             input int unsigned tx_pct, input int unsigned rx_pct,
                             input bit hold_off);
        int unsigned target;
        int unsigned pick;
        settle();
        write_settings(tpc, limit);
        tx_idle_pct = tx_pct;
        rx_idle_pct <= rx_pct;
        if (hold_off) begin
            // receiver stalls for a long stretch while the sender keeps offering
            fork
                begin
                    rx_hold <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                    rx_hold <= 1'b0;
                end
            join_none
        end
        // with the widest limit a long run of polls is needed to reach the timeout
        // and to see the poll count sit at its top
        if (limit == POLL_LIMIT_RESET) begin
            send(OP_START, 1'b0, 1'b0, '0);
            repeat (STORM_POLLS) send(OP_POLL, rand_bit(), rand_bit(), '0);
        end
        target = items_sent + PHASE_ITEMS;
        while (items_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 65) begin
                run_measurement();
            end else if (pick < 80) begin
                run_timeout();
            end else begin
                send(OPCODE_W'($urandom_range(3)), rand_bit(), rand_bit(), rand_capture());
            end
        end
    endtask

    initial begin
        // everything known from time zero
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_index         = CFG_TICKS_PER_CM;
        i_cfg_data          = '0;
        in_if.valid         = 1'b0;
        in_if.opcode        = OP_START;
        in_if.overflow_seen = 1'b0;
        in_if.edge_seen     = 1'b0;
        in_if.capture_value = '0;
        out_if.ready        = 1'b0;
        rx_hold             = 1'b0;
        items_sent          = 0;
        tx_idle_pct         = 10;
        rx_idle_pct         = 72;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, on the reset register values
        send(OP_POLL,   1'b0, 1'b0, '0);              // poll before anything
        send(OP_TIMER,  1'b1, 1'b1, COUNT_MAX);       // unarmed timer event is ignored
        send(OP_UNUSED, 1'b1, 1'b1, COUNT_MAX);       // unused opcode
        send(OP_START,  1'b0, 1'b0, '0);
        send(OP_TIMER,  1'b1, 1'b0, '0);              // overflow before the pulse is ignored
        send(OP_TIMER,  1'b0, 1'b1, '0);              // rising edge
        send(OP_START,  1'b1, 1'b1, COUNT_MAX);       // start keeps the pulse in progress
        send(OP_TIMER,  1'b1, 1'b0, 32'h5555_5555);
        send(OP_TIMER,  1'b1, 1'b1, COUNT_MAX);       // overflow and falling edge together
        send(OP_TIMER,  1'b0, 1'b1, '0);              // ignored once done
        send(OP_POLL,   1'b1, 1'b1, COUNT_MAX);       // saturated distance
        send(OP_POLL,   1'b0, 1'b0, '0);
        send(OP_START,  1'b0, 1'b0, '0);
        send(OP_TIMER,  1'b0, 1'b1, 32'hAAAA_AAAA);
        send(OP_TIMER,  1'b0, 1'b1, '0);              // zero width pulse
        send(OP_POLL,   1'b0, 1'b0, '0);
        send(OP_START,  1'b0, 1'b0, '0);
        send(OP_TIMER,  1'b0, 1'b1, 32'd12345);
        send(OP_TIMER,  1'b0, 1'b1, 32'd5800);        // one metre at the reset scale
        send(OP_POLL,   1'b0, 1'b0, '0);

        // random phases: receiver-heavy idling, then sender-heavy, then none
        run_phase(16'd1,     8'd1,   10, 72, 1'b0);
        run_phase(16'd65535, 8'd255, 10, 72, 1'b0);
        run_phase(16'd0,     8'd2,   72, 10, 1'b0);
        run_phase(16'd58,    8'd6,   72, 10, 1'b0);
        run_phase(16'd40000, 8'd0,   0,  0,  1'b1);
        run_phase(16'd3000,  8'd3,   0,  0,  1'b0);

        settle();
        if (board.errors == 0 && board.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
